// ----- sv/line_and_fill_pixel_rasterizer_core_assert.svh -----
// Assertion macros for the rasterizer checker file
`ifndef LINE_AND_FILL_PIXEL_RASTERIZER_CORE_ASSERT_SVH
`define LINE_AND_FILL_PIXEL_RASTERIZER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while rst_n is low
`define LFPR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("lfpr assertion failed");

// Next-cycle implication, disabled while rst_n is low
`define LFPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("lfpr assertion failed");

`endif

// ----- sv/lfpr_pkg.sv -----
// Package: types, constants and color packing for the pixel rasterizer
`timescale 1ns / 1ps
`default_nettype none

package lfpr_pkg;

  localparam int COORD_BITS = 11;
  localparam int DELTA_BITS = COORD_BITS + 1;
  localparam int ERR_BITS   = COORD_BITS + 3;
  localparam int DIM_BITS   = 12;
  localparam int INDEX_BITS = 22;
  localparam int PROD_BITS  = 2 * DIM_BITS;
  localparam int RGB_BITS   = 24;
  localparam int PIX_BITS   = 16;
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 3;

  localparam logic [DIM_BITS-1:0] WIDTH_RESET  = 12'd800;
  localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 12'd480;

  typedef enum logic [1:0] {
    CMD_LINE = 2'd0,
    CMD_FILL = 2'd1,
    CMD_STEP = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_LINE = 2'd1,
    MODE_FILL = 2'd2
  } mode_t;

  // Register index, taken from the word address
  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  // Current pixel as seen by the output stage
  typedef struct packed {
    logic                  active;
    logic                  done;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [PIX_BITS-1:0]   rgb565;
  } pix_t;

  function automatic logic [PIX_BITS-1:0] to_rgb565(input logic [RGB_BITS-1:0] rgb);
    return {rgb[23:19], rgb[15:10], rgb[7:3]};
  endfunction

endpackage

`default_nettype wire

// ----- sv/lfpr_walker.sv -----
// Shape walker: Bresenham line and row-by-row fill state with per-step advance
`timescale 1ns / 1ps
`default_nettype none

module lfpr_walker
  import lfpr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  xfer,
  input  wire cmd_t                  command,
  input  wire logic [COORD_BITS-1:0] x_start,
  input  wire logic [COORD_BITS-1:0] y_start,
  input  wire logic [COORD_BITS-1:0] x_end,
  input  wire logic [COORD_BITS-1:0] y_end,
  input  wire logic [RGB_BITS-1:0]   color,
  output pix_t                       pix
);

  mode_t                        mode_r, mode_nxt;
  logic [COORD_BITS-1:0]        cur_x_r, cur_x_nxt;
  logic [COORD_BITS-1:0]        cur_y_r, cur_y_nxt;
  logic [COORD_BITS-1:0]        row_x_r, row_x_nxt;
  logic [COORD_BITS-1:0]        tgt_x_r, tgt_x_nxt;
  logic [COORD_BITS-1:0]        tgt_y_r, tgt_y_nxt;
  logic [DELTA_BITS-1:0]        dx_r, dx_nxt;
  logic [DELTA_BITS-1:0]        dy_r, dy_nxt;
  logic                         neg_x_r, neg_x_nxt;
  logic                         neg_y_r, neg_y_nxt;
  logic signed [ERR_BITS-1:0]   err_r, err_nxt;
  logic [PIX_BITS-1:0]          rgb_r, rgb_nxt;

  logic                         done;
  logic [DELTA_BITS-1:0]        ld_dx, ld_dy;
  logic signed [ERR_BITS:0]     e2;
  logic signed [ERR_BITS:0]     dx_s, dy_s;
  logic                         mv_x, mv_y;
  logic signed [ERR_BITS-1:0]   err_step;
  logic [COORD_BITS-1:0]        line_x, line_y;

  // Last pixel when the walk reaches the target corner
  assign done = (cur_x_r == tgt_x_r) && (cur_y_r == tgt_y_r);

  // Absolute deltas for a line start
  assign ld_dx = (x_end > x_start) ? DELTA_BITS'(x_end - x_start)
                                   : DELTA_BITS'(x_start - x_end);
  assign ld_dy = (y_end > y_start) ? DELTA_BITS'(y_end - y_start)
                                   : DELTA_BITS'(y_start - y_end);

  // Bresenham decision on the doubled error term
  assign e2   = {err_r, 1'b0};
  assign dx_s = (ERR_BITS+1)'(dx_r);
  assign dy_s = (ERR_BITS+1)'(dy_r);
  assign mv_x = e2 > -dy_s;
  assign mv_y = e2 < dx_s;

  always_comb begin
    err_step = err_r;
    if (mv_x) begin
      err_step = err_step - ERR_BITS'(dy_r);
    end
    if (mv_y) begin
      err_step = err_step + ERR_BITS'(dx_r);
    end
  end

  assign line_x = mv_x ? (neg_x_r ? cur_x_r - 1'b1 : cur_x_r + 1'b1) : cur_x_r;
  assign line_y = mv_y ? (neg_y_r ? cur_y_r - 1'b1 : cur_y_r + 1'b1) : cur_y_r;

  // Next state: load on start, advance on step
  always_comb begin
    mode_nxt  = mode_r;
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    row_x_nxt = row_x_r;
    tgt_x_nxt = tgt_x_r;
    tgt_y_nxt = tgt_y_r;
    dx_nxt    = dx_r;
    dy_nxt    = dy_r;
    neg_x_nxt = neg_x_r;
    neg_y_nxt = neg_y_r;
    err_nxt   = err_r;
    rgb_nxt   = rgb_r;
    if (xfer) begin
      case (command)
        CMD_LINE: begin
          cur_x_nxt = x_start;
          cur_y_nxt = y_start;
          row_x_nxt = x_start;
          tgt_x_nxt = x_end;
          tgt_y_nxt = y_end;
          dx_nxt    = ld_dx;
          dy_nxt    = ld_dy;
          neg_x_nxt = !(x_start < x_end);
          neg_y_nxt = !(y_start < y_end);
          err_nxt   = ERR_BITS'(ld_dx) - ERR_BITS'(ld_dy);
          rgb_nxt   = to_rgb565(color);
          mode_nxt  = MODE_LINE;
        end
        CMD_FILL: begin
          cur_x_nxt = x_start;
          cur_y_nxt = y_start;
          row_x_nxt = x_start;
          tgt_x_nxt = x_end;
          tgt_y_nxt = y_end;
          rgb_nxt   = to_rgb565(color);
          mode_nxt  = (x_start > x_end || y_start > y_end) ? MODE_IDLE : MODE_FILL;
        end
        CMD_STEP: begin
          if (mode_r != MODE_IDLE) begin
            if (done) begin
              mode_nxt = MODE_IDLE;
            end else if (mode_r == MODE_LINE) begin
              err_nxt   = err_step;
              cur_x_nxt = line_x;
              cur_y_nxt = line_y;
            end else if (cur_x_r == tgt_x_r) begin
              cur_x_nxt = row_x_r;
              cur_y_nxt = cur_y_r + 1'b1;
            end else begin
              cur_x_nxt = cur_x_r + 1'b1;
            end
          end
        end
        default: begin
          mode_nxt = mode_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      cur_x_r <= '0;
      cur_y_r <= '0;
      row_x_r <= '0;
      tgt_x_r <= '0;
      tgt_y_r <= '0;
      dx_r    <= '0;
      dy_r    <= '0;
      neg_x_r <= 1'b0;
      neg_y_r <= 1'b0;
      err_r   <= '0;
      rgb_r   <= '0;
    end else begin
      mode_r  <= mode_nxt;
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
      row_x_r <= row_x_nxt;
      tgt_x_r <= tgt_x_nxt;
      tgt_y_r <= tgt_y_nxt;
      dx_r    <= dx_nxt;
      dy_r    <= dy_nxt;
      neg_x_r <= neg_x_nxt;
      neg_y_r <= neg_y_nxt;
      err_r   <= err_nxt;
      rgb_r   <= rgb_nxt;
    end
  end

  assign pix.active = (mode_r != MODE_IDLE);
  assign pix.done   = done;
  assign pix.x      = cur_x_r;
  assign pix.y      = cur_y_r;
  assign pix.rgb565 = rgb_r;

endmodule

`default_nettype wire

// ----- sv/line_and_fill_pixel_rasterizer_core.sv -----
// Top level: command channel, APB registers, clip and rotate, pixel output register
//
// Usage: the in_ channel takes commands. A line or fill start loads the shape
// and color and gives no result; a step gives one pixel result while a shape
// is active and nothing while idle. An empty rectangle leaves the block idle.
// The out_ channel carries write_valid (pixel on screen), the rotated word
// index (width-1-x)*height+y, the RGB565 color and done on the last pixel.
// A step's pixel goes through one register stage, the output register.
// Throughput: one command per cycle unless the output stalls; the rate is set
// by the walker advancing one pixel per step and the single output register,
// which reloads in the same cycle that it drains. in_ready drops only while a
// pixel waits and out_ready is low; the pending pixel then holds. The user must
// write width and height over APB at byte addresses 0 and 4 only while the
// block is idle (not enforced). Reset (synchronous, active low) clears the
// walker to idle, drops out_valid and restores width 800 and height 480.
`timescale 1ns / 1ps
`default_nettype none

module line_and_fill_pixel_rasterizer_core
  import lfpr_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // command channel
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [1:0]               in_command,
  input  wire logic [COORD_BITS-1:0]    in_x_start,
  input  wire logic [COORD_BITS-1:0]    in_y_start,
  input  wire logic [COORD_BITS-1:0]    in_x_end,
  input  wire logic [COORD_BITS-1:0]    in_y_end,
  input  wire logic [RGB_BITS-1:0]      in_color,
  // pixel channel
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic                          out_write_valid,
  output logic [INDEX_BITS-1:0]         out_pixel_index,
  output logic [PIX_BITS-1:0]           out_pixel_rgb565,
  output logic                          out_done_res,
  // configuration
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [APB_ADDR_BITS-1:0] paddr,
  input  wire logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0]      prdata,
  output logic                          pready
);

  logic [DIM_BITS-1:0]   width_r, width_nxt;
  logic [DIM_BITS-1:0]   height_r, height_nxt;
  logic                  cfg_wr;
  reg_idx_t              reg_sel;

  logic                  xfer;
  cmd_t                  cmd;
  pix_t                  pix;

  logic                  emit;
  logic                  on_screen;
  logic [DIM_BITS-1:0]   col;
  logic [PROD_BITS-1:0]  prod;
  logic [PROD_BITS-1:0]  lin;

  logic                  ov_r, ov_nxt;
  logic                  wv_r, wv_nxt;
  logic [INDEX_BITS-1:0] idx_r, idx_nxt;
  logic [PIX_BITS-1:0]   rgb_r, rgb_nxt;
  logic                  done_r, done_nxt;

  // Register file
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = reg_idx_t'(paddr[2]);

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_wr) begin
      case (reg_sel)
        REG_WIDTH:  width_nxt  = pwdata[DIM_BITS-1:0];
        REG_HEIGHT: height_nxt = pwdata[DIM_BITS-1:0];
        default:    width_nxt  = width_r;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_WIDTH:  prdata = APB_DATA_BITS'(width_r);
      REG_HEIGHT: prdata = APB_DATA_BITS'(height_r);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  // Command transfer: accept while the output slot is free or draining
  assign in_ready = !ov_r || out_ready;
  assign xfer     = in_valid && in_ready;
  assign cmd      = cmd_t'(in_command);

  lfpr_walker u_walker (
    .clk     (clk),
    .rst_n   (rst_n),
    .xfer    (xfer),
    .command (cmd),
    .x_start (in_x_start),
    .y_start (in_y_start),
    .x_end   (in_x_end),
    .y_end   (in_y_end),
    .color   (in_color),
    .pix     (pix)
  );

  // Clip and rotate the current pixel
  assign emit      = xfer && (cmd == CMD_STEP) && pix.active;
  assign on_screen = (DIM_BITS'(pix.x) < width_r) && (DIM_BITS'(pix.y) < height_r);
  assign col       = width_r - 1'b1 - DIM_BITS'(pix.x);
  assign prod      = PROD_BITS'(col) * PROD_BITS'(height_r);
  assign lin       = prod + PROD_BITS'(pix.y);

  // Output register: load on a step, drop on transfer out
  always_comb begin
    ov_nxt   = ov_r;
    wv_nxt   = wv_r;
    idx_nxt  = idx_r;
    rgb_nxt  = rgb_r;
    done_nxt = done_r;
    if (emit) begin
      ov_nxt   = 1'b1;
      wv_nxt   = on_screen;
      idx_nxt  = on_screen ? lin[INDEX_BITS-1:0] : '0;
      rgb_nxt  = pix.rgb565;
      done_nxt = pix.done;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wv_r   <= wv_nxt;
    idx_r  <= idx_nxt;
    rgb_r  <= rgb_nxt;
    done_r <= done_nxt;
  end

  assign out_valid        = ov_r;
  assign out_write_valid  = wv_r;
  assign out_pixel_index  = idx_r;
  assign out_pixel_rgb565 = rgb_r;
  assign out_done_res     = done_r;

endmodule

`default_nettype wire

// ----- sv/lfpr_checker.sv -----
// Port-level checker for the rasterizer, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "line_and_fill_pixel_rasterizer_core_assert.svh"

module lfpr_checker
  import lfpr_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic [1:0]            in_command,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic                  out_write_valid,
  input wire logic [INDEX_BITS-1:0] out_pixel_index
);

  logic start_xfer;
  logic held;

  assign start_xfer = in_valid && in_ready && (in_command != CMD_STEP);
  assign held       = out_valid && !out_ready;

  // Reset leaves no pixel pending
  `LFPR_ASSERT_NEXT(a_reset_clears, clk, 1'b1, !rst_n, !out_valid)

  // Input side opens whenever the output slot can take a pixel
  `LFPR_ASSERT_IMPL(a_ready_skid, clk, rst_n, 1'b1, in_ready == (!out_valid || out_ready))

  // A start or idle command never produces a pixel
  `LFPR_ASSERT_NEXT(a_start_silent, clk, rst_n, start_xfer && !held, !out_valid)

  // A clipped pixel carries a zero index
  `LFPR_ASSERT_IMPL(a_clip_zero, clk, rst_n, out_valid && !out_write_valid,
                    out_pixel_index == '0)

  // A stalled pixel holds its index
  `LFPR_ASSERT_NEXT(a_stall_hold, clk, rst_n, held, out_valid && $stable(out_pixel_index))

endmodule

bind line_and_fill_pixel_rasterizer_core lfpr_checker u_lfpr_checker (.*);

`default_nettype wire
